// ===== rtl/erate_pkg.sv =====
// ----------------------------------------------------------------------------
// erate_pkg
// Shared types, constants and helpers of the error rate tracker: Q1.16
// fraction type, register indexes, class codes, controller states and the
// command bundle from controller to datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package erate_pkg;

	// fractions are unsigned Q1.16 held in 17 bits, 65536 is one
	localparam int unsigned Q_W     = 17;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned PROD_W  = 36;

	typedef logic [Q_W-1:0]   q16_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] cfg_idx_t;

	localparam q16_t ONE_Q16     = 17'd65536;
	localparam q16_t HALF_Q16    = 17'd32768;
	localparam q16_t QUARTER_Q16 = 17'd16384;
	localparam q16_t ZERO_Q16    = 17'd0;

	// reset values of the forget factor registers
	localparam q16_t GEN_FORGET_RST   = 17'd3277;
	localparam q16_t LOCAL_FORGET_RST = 17'd197;
	localparam q16_t GOOD_FORGET_RST  = 17'd3277;
	localparam q16_t BAD_FORGET_RST   = 17'd3277;

	localparam cnt_t CNT_MAX = '1;

	// configuration register indexes
	localparam cfg_idx_t REG_GEN_FORGET   = 3'd0;
	localparam cfg_idx_t REG_LOCAL_FORGET = 3'd1;
	localparam cfg_idx_t REG_GOOD_FORGET  = 3'd2;
	localparam cfg_idx_t REG_BAD_FORGET   = 3'd3;

	// target class codes
	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_GOOD   = 2'd1,
		CLS_BAD    = 2'd2,
		CLS_UNUSED = 2'd3
	} class_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLS,
		ST_RMIN,
		ST_RMAX,
		ST_FIN
	} state_t;

	// operand selection of the shared blend multiplier
	typedef enum logic [1:0] {
		MUL_GEN,
		MUL_CLS,
		MUL_RMIN,
		MUL_RMAX
	} mul_sel_t;

	// command bundle from controller to datapath
	typedef struct packed {
		logic     accept;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     wr_gen;
		logic     wr_cls;
		logic     wr_rmin;
		logic     wr_rmax;
		logic     out_load;
	} cmd_t;

	// clamp a fraction at one
	function automatic q16_t sat_one(input q16_t v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/erate_ctrl.sv =====
// ----------------------------------------------------------------------------
// erate_ctrl
// Sequencer of the error rate tracker. Steps one request through the four
// blend operations of the shared multiplier and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module erate_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output erate_pkg::cmd_t    cmd
);
	import erate_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a new result
	assign out_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_CLS;
				end
			end
			ST_CLS:  state_nxt = ST_RMIN;
			ST_RMIN: state_nxt = ST_RMAX;
			ST_RMAX: state_nxt = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_GEN;
		case (state_q)
			ST_IDLE: begin
				cmd.accept  = in_valid;
				cmd.mul_en  = in_valid;
				cmd.mul_sel = MUL_GEN;
			end
			ST_CLS: begin
				cmd.wr_gen  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CLS;
			end
			ST_RMIN: begin
				cmd.wr_cls  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RMIN;
			end
			ST_RMAX: begin
				cmd.wr_rmin = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RMAX;
			end
			ST_FIN: begin
				cmd.wr_rmax  = out_free;
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/erate_dp.sv =====
// ----------------------------------------------------------------------------
// erate_dp
// Datapath of the error rate tracker: forget factor registers, tracker
// state, one shared blend multiplier with registered product, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module erate_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire erate_pkg::cmd_t      cmd,
	input  wire logic                 cfg_we,
	input  wire erate_pkg::cfg_idx_t  cfg_index,
	input  wire erate_pkg::q16_t      cfg_data,
	input  wire erate_pkg::q16_t      error_value,
	input  wire logic [1:0]           target_class,
	output erate_pkg::q16_t           gen_error_rate,
	output erate_pkg::q16_t           gen_min,
	output erate_pkg::q16_t           gen_max,
	output erate_pkg::q16_t           local_min,
	output erate_pkg::q16_t           local_max,
	output erate_pkg::q16_t           good_error_rate,
	output erate_pkg::q16_t           good_min,
	output erate_pkg::q16_t           good_max,
	output erate_pkg::q16_t           bad_error_rate,
	output erate_pkg::q16_t           best_mean_rate,
	output erate_pkg::cnt_t           steps_since_best,
	output erate_pkg::q16_t           reliance_weight
);
	import erate_pkg::*;

	// forget factor registers
	q16_t gen_forget_q, local_forget_q, good_forget_q, bad_forget_q;

	// tracker state
	q16_t overall_q, omin_q, omax_q, rmin_q, rmax_q;
	q16_t good_q, glow_q, ghigh_q, bad_q, best_q;
	cnt_t step_q;

	// latched request
	q16_t   err_q;
	class_t cls_q;

	// blend unit
	q16_t                     mul_v, mul_x, mul_f;
	logic signed [Q_W:0]      diff;
	logic signed [Q_W:0]      fs;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	q16_t                     base_s1;
	logic [PROD_W-1:0]        rnd_full;
	q16_t                     blend_res;

	// class update helpers
	logic [Q_W:0] cls_sum;
	logic         improve;
	q16_t         rmax_nxt;
	logic [Q_W:0] rel_sum;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_forget_q   <= GEN_FORGET_RST;
			local_forget_q <= LOCAL_FORGET_RST;
			good_forget_q  <= GOOD_FORGET_RST;
			bad_forget_q   <= BAD_FORGET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GEN_FORGET:   gen_forget_q   <= cfg_data;
				REG_LOCAL_FORGET: local_forget_q <= cfg_data;
				REG_GOOD_FORGET:  good_forget_q  <= cfg_data;
				REG_BAD_FORGET:   bad_forget_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			err_q <= sat_one(error_value);
			cls_q <= class_t'(target_class);
		end
	end

	// blend operand selection
	always_comb begin
		case (cmd.mul_sel)
			MUL_GEN: begin
				mul_v = overall_q;
				mul_x = sat_one(error_value);
				mul_f = sat_one(gen_forget_q);
			end
			MUL_CLS: begin
				mul_v = (cls_q == CLS_GOOD) ? good_q : bad_q;
				mul_x = err_q;
				mul_f = (cls_q == CLS_GOOD) ? sat_one(good_forget_q)
				                            : sat_one(bad_forget_q);
			end
			MUL_RMIN: begin
				mul_v = rmin_q;
				mul_x = overall_q;
				mul_f = sat_one(local_forget_q);
			end
			MUL_RMAX: begin
				mul_v = rmax_q;
				mul_x = overall_q;
				mul_f = sat_one(local_forget_q);
			end
			default: begin
				mul_v = overall_q;
				mul_x = err_q;
				mul_f = ZERO_Q16;
			end
		endcase
	end

	// v + f*(x - v), product registered
	assign diff = $signed({1'b0, mul_x}) - $signed({1'b0, mul_v});
	assign fs   = $signed({1'b0, mul_f});
	assign prod = fs * diff;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= prod;
			base_s1 <= mul_v;
		end
	end

	// round half up, result known to fit in 17 bits so wrap is exact
	assign rnd_full  = prod_s1 + PROD_W'(HALF_Q16);
	assign blend_res = base_s1 + rnd_full[Q_W+15:16];

	// best mean check on the freshly updated class rate
	always_comb begin
		if (cls_q == CLS_GOOD) begin
			cls_sum = {1'b0, blend_res} + {1'b0, bad_q};
		end else begin
			cls_sum = {1'b0, good_q} + {1'b0, blend_res};
		end
		improve = (cls_sum < {best_q, 1'b0});
	end

	assign rmax_nxt = (overall_q > rmax_q) ? overall_q : blend_res;

	// tracker state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_q <= HALF_Q16;
			omin_q    <= HALF_Q16;
			omax_q    <= ZERO_Q16;
			rmin_q    <= QUARTER_Q16;
			rmax_q    <= QUARTER_Q16;
			good_q    <= HALF_Q16;
			glow_q    <= HALF_Q16;
			ghigh_q   <= ZERO_Q16;
			bad_q     <= HALF_Q16;
			best_q    <= ONE_Q16;
			step_q    <= '0;
		end else begin
			// overall rate with global extremes and step count
			if (cmd.wr_gen) begin
				overall_q <= blend_res;
				if (blend_res < omin_q) begin
					omin_q <= blend_res;
				end
				if (blend_res > omax_q) begin
					omax_q <= blend_res;
				end
				if (step_q != CNT_MAX) begin
					step_q <= step_q + 1'b1;
				end
			end
			// class rate and best mean
			if (cmd.wr_cls && (cls_q == CLS_GOOD || cls_q == CLS_BAD)) begin
				if (cls_q == CLS_GOOD) begin
					good_q <= blend_res;
					if (blend_res < glow_q) begin
						glow_q <= blend_res;
					end
					if (blend_res > ghigh_q) begin
						ghigh_q <= blend_res;
					end
				end else begin
					bad_q <= blend_res;
				end
				if (improve) begin
					best_q <= cls_sum[Q_W:1];
					step_q <= '0;
				end
			end
			// local extremes
			if (cmd.wr_rmin) begin
				rmin_q <= (overall_q < rmin_q) ? overall_q : blend_res;
			end
			if (cmd.wr_rmax) begin
				rmax_q <= rmax_nxt;
			end
		end
	end

	// reliance weight from the class rates
	assign rel_sum = {1'b0, good_q} + {1'b0, bad_q};

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			gen_error_rate   <= overall_q;
			gen_min          <= omin_q;
			gen_max          <= omax_q;
			local_min        <= rmin_q;
			local_max        <= rmax_nxt;
			good_error_rate  <= good_q;
			good_min         <= glow_q;
			good_max         <= ghigh_q;
			bad_error_rate   <= bad_q;
			best_mean_rate   <= best_q;
			steps_since_best <= step_q;
			reliance_weight  <= (rel_sum >= {1'b0, ONE_Q16}) ? ZERO_Q16
			                    : Q_W'({1'b0, ONE_Q16} - rel_sum);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/error_rate_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// error_rate_tracker_unit
// Classifier error rate tracker: smoothed overall, good-class and bad-class
// error rates with extremes, best mean with age, and reliance weight.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  in       | in_valid / in_stall      | error_value, target_class
//  out      | out_valid / out_stall    | twelve rate and counter fields
//  cfg      | cfg_we (no wait)         | cfg_index, cfg_data
//
//  A request runs from its accept through ST_CLS, ST_RMIN, ST_RMAX and
//  ST_FIN, as four dependent blends share one registered 18x18 multiplier.
//  in_stall is high from the accept until the result enters the output
//  register; a stalled output holds the last cycle until it is taken.
//  Reset restores all rates, extremes, counters and forget factors.
//
`default_nettype none

module error_rate_tracker_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire erate_pkg::q16_t      error_value,
	input  wire logic [1:0]           target_class,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output erate_pkg::q16_t           gen_error_rate,
	output erate_pkg::q16_t           gen_min,
	output erate_pkg::q16_t           gen_max,
	output erate_pkg::q16_t           local_min,
	output erate_pkg::q16_t           local_max,
	output erate_pkg::q16_t           good_error_rate,
	output erate_pkg::q16_t           good_min,
	output erate_pkg::q16_t           good_max,
	output erate_pkg::q16_t           bad_error_rate,
	output erate_pkg::q16_t           best_mean_rate,
	output erate_pkg::cnt_t           steps_since_best,
	output erate_pkg::q16_t           reliance_weight,
	input  wire logic                 cfg_we,
	input  wire erate_pkg::cfg_idx_t  cfg_index,
	input  wire erate_pkg::q16_t      cfg_data
);
	import erate_pkg::*;

	cmd_t cmd;

	// sequencer
	erate_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	erate_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.error_value      (error_value),
		.target_class     (target_class),
		.gen_error_rate   (gen_error_rate),
		.gen_min          (gen_min),
		.gen_max          (gen_max),
		.local_min        (local_min),
		.local_max        (local_max),
		.good_error_rate  (good_error_rate),
		.good_min         (good_min),
		.good_max         (good_max),
		.bad_error_rate   (bad_error_rate),
		.best_mean_rate   (best_mean_rate),
		.steps_since_best (steps_since_best),
		.reliance_weight  (reliance_weight)
	);

	// a request keeps the unit busy on the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("unit not busy after accepting a request");

	// global extremes bracket the overall rate
	a_global_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gen_min <= gen_error_rate && gen_max >= gen_error_rate))
		else $error("global min/max do not bracket overall rate");

	// local extremes bracket the overall rate
	a_local_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (local_min <= gen_error_rate && local_max >= gen_error_rate))
		else $error("local min/max do not bracket overall rate");

	// good-class extremes are ordered once a good request has been seen
	a_good_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && good_max != ZERO_Q16) |->
			(good_min <= good_error_rate && good_max >= good_error_rate))
		else $error("good min/max do not bracket good rate");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the error rate tracker. A queue of error requests
// feeds a clocked driver; a clocked monitor compares every report with a
// local Q1.16 tracker model. Runs a directed opener, then several random
// phases under different forget factors and idle/stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import erate_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned SETTLE_CYCLES   = 12;
	localparam int unsigned PHASE_REQS      = 205;
	localparam int unsigned RANDOM_PHASES   = 8;
	localparam cfg_idx_t    REG_SPARE_FIRST = REG_BAD_FORGET + 3'd1;
	localparam cfg_idx_t    REG_SPARE_LAST  = '1;
	localparam q16_t        FACTOR_ALL_ONES = '1;

	// one error request as queued for the driver
	typedef struct {
		q16_t   err;
		class_t cls;
		bit     drain;
	} err_req_t;

	// one predicted tracker report
	typedef struct {
		q16_t gen_rate;
		q16_t gen_lo;
		q16_t gen_hi;
		q16_t loc_lo;
		q16_t loc_hi;
		q16_t good_rt;
		q16_t good_lo;
		q16_t good_hi;
		q16_t bad_rt;
		q16_t best;
		cnt_t age;
		q16_t weight;
	} rate_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	q16_t error_value = '0;
	logic [1:0] target_class = CLS_NONE;
	logic out_valid;
	logic out_stall = 1'b0;
	q16_t gen_error_rate, gen_min, gen_max, local_min, local_max;
	q16_t good_error_rate, good_min, good_max, bad_error_rate;
	q16_t best_mean_rate, reliance_weight;
	cnt_t steps_since_best;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = '0;
	q16_t cfg_data = '0;

	err_req_t err_req_q[$];
	rate_report_t report_q[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned req_cnt = 0;
	int unsigned report_cnt = 0;
	int unsigned best_hits = 0;
	bit req_taken;
	rate_report_t want;

	// forget factors as last written
	q16_t gen_fac = GEN_FORGET_RST;
	q16_t loc_fac = LOCAL_FORGET_RST;
	q16_t good_fac = GOOD_FORGET_RST;
	q16_t bad_fac = BAD_FORGET_RST;

	// tracker state
	q16_t ovr_rate = HALF_Q16;
	q16_t ovr_lo = HALF_Q16;
	q16_t ovr_hi = ZERO_Q16;
	q16_t rec_lo = QUARTER_Q16;
	q16_t rec_hi = QUARTER_Q16;
	q16_t good_rt = HALF_Q16;
	q16_t good_lo = HALF_Q16;
	q16_t good_hi = ZERO_Q16;
	q16_t bad_rt = HALF_Q16;
	q16_t best_avg = ONE_Q16;
	cnt_t best_age = '0;

	error_rate_tracker_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.error_value      (error_value),
		.target_class     (target_class),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.gen_error_rate   (gen_error_rate),
		.gen_min          (gen_min),
		.gen_max          (gen_max),
		.local_min        (local_min),
		.local_max        (local_max),
		.good_error_rate  (good_error_rate),
		.good_min         (good_min),
		.good_max         (good_max),
		.bad_error_rate   (bad_error_rate),
		.best_mean_rate   (best_mean_rate),
		.steps_since_best (steps_since_best),
		.reliance_weight  (reliance_weight),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// blend v toward x by factor f, factor clamped at one, round half up
	function automatic q16_t mix(q16_t v, q16_t x, q16_t f);
		logic [63:0] fs;
		logic [63:0] acc;
		fs = (f > ONE_Q16) ? 64'(ONE_Q16) : 64'(f);
		acc = (64'(ONE_Q16) - fs) * 64'(v) + fs * 64'(x) + 64'(HALF_Q16);
		acc = acc >> 16;
		return (acc > 64'(ONE_Q16)) ? ONE_Q16 : q16_t'(acc);
	endfunction

	// advance the tracker by one request and return its report
	function automatic rate_report_t track_error(q16_t err_raw, class_t cls);
		rate_report_t r;
		q16_t err;
		logic [17:0] pair_sum;
		err = (err_raw > ONE_Q16) ? ONE_Q16 : err_raw;
		if (best_age != '1)
			best_age++;

		// overall rate with global and decaying extremes
		ovr_rate = mix(ovr_rate, err, gen_fac);
		if (ovr_rate < ovr_lo)
			ovr_lo = ovr_rate;
		if (ovr_rate > ovr_hi)
			ovr_hi = ovr_rate;
		rec_lo = (ovr_rate < rec_lo) ? ovr_rate : mix(rec_lo, ovr_rate, loc_fac);
		rec_hi = (ovr_rate > rec_hi) ? ovr_rate : mix(rec_hi, ovr_rate, loc_fac);

		// class rates, then best mean of the pair
		if (cls == CLS_GOOD) begin
			good_rt = mix(good_rt, err, good_fac);
			if (good_rt < good_lo)
				good_lo = good_rt;
			if (good_rt > good_hi)
				good_hi = good_rt;
		end else if (cls == CLS_BAD) begin
			bad_rt = mix(bad_rt, err, bad_fac);
		end
		pair_sum = 18'(good_rt) + 18'(bad_rt);
		if ((cls == CLS_GOOD || cls == CLS_BAD) && pair_sum < {1'b0, best_avg, 1'b0}) begin
			best_avg = q16_t'(pair_sum >> 1);
			best_age = '0;
			best_hits++;
		end

		r.gen_rate = ovr_rate;
		r.gen_lo = ovr_lo;
		r.gen_hi = ovr_hi;
		r.loc_lo = rec_lo;
		r.loc_hi = rec_hi;
		r.good_rt = good_rt;
		r.good_lo = good_lo;
		r.good_hi = good_hi;
		r.bad_rt = bad_rt;
		r.best = best_avg;
		r.age = best_age;
		r.weight = (pair_sum >= 18'(ONE_Q16)) ? ZERO_Q16 : q16_t'(18'(ONE_Q16) - pair_sum);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_cnt++;
		end
	endfunction

	function automatic void push_req(q16_t e, class_t c, bit d);
		err_req_t q;
		q.err = e;
		q.cls = c;
		q.drain = d;
		err_req_q.insert(err_req_q.size(), q);
	endfunction

	// forget factor for a random phase, extremes included
	function automatic q16_t pick_factor();
		case ($urandom_range(5))
			0: return ZERO_Q16;
			1: return ONE_Q16;
			2: return q16_t'($urandom_range(131071, 65537));
			default: return q16_t'($urandom_range(20000, 1));
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			error_value <= '0;
			target_class <= CLS_NONE;
		end else begin
			req_taken = in_valid && !in_stall;
			if (req_taken) begin
				report_q.insert(report_q.size(),
				                track_error(error_value, class_t'(target_class)));
				req_cnt++;
			end
			// next request, held back while a drain point waits for the pipe to empty
			if (!in_valid || req_taken) begin
				if (err_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(err_req_q[0].drain && report_q.size() != 0)) begin
					in_valid <= 1'b1;
					error_value <= err_req_q[0].err;
					target_class <= err_req_q[0].cls;
					void'(err_req_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// report monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				report_cnt++;
				if (report_q.size() == 0) begin
					$error("report with no request outstanding");
					mismatch_cnt++;
				end else begin
					want = report_q.pop_front();
					check_field("gen_error_rate", want.gen_rate, gen_error_rate);
					check_field("gen_min", want.gen_lo, gen_min);
					check_field("gen_max", want.gen_hi, gen_max);
					check_field("local_min", want.loc_lo, local_min);
					check_field("local_max", want.loc_hi, local_max);
					check_field("good_error_rate", want.good_rt, good_error_rate);
					check_field("good_min", want.good_lo, good_min);
					check_field("good_max", want.good_hi, good_max);
					check_field("bad_error_rate", want.bad_rt, bad_error_rate);
					check_field("best_mean_rate", want.best, best_mean_rate);
					check_field("steps_since_best", want.age, steps_since_best);
					check_field("reliance_weight", want.weight, reliance_weight);
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// run time guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// register write, mirrored once it has taken effect
	task automatic write_reg(cfg_idx_t idx, q16_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GEN_FORGET:   gen_fac = val;
			REG_LOCAL_FORGET: loc_fac = val;
			REG_GOOD_FORGET:  good_fac = val;
			REG_BAD_FORGET:   bad_fac = val;
			default: ;
		endcase
	endtask

	// wait until no request is queued, in flight or awaiting its report
	task automatic wait_drained();
		do
			@(negedge clk);
		while (err_req_q.size() != 0 || in_valid || report_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// runs of requests around a drifting error level, class mix per run
	task automatic add_random_reqs(int unsigned total, bit force_drain);
		int unsigned made;
		int unsigned n;
		int unsigned mode;
		int unsigned i;
		int unsigned pick;
		q16_t level, spread, lo, hi, e;
		class_t c;
		bit d;
		made = 0;
		while (made < total) begin
			n = $urandom_range(40, 8);
			if ($urandom_range(3) == 0)
				level = $urandom_range(1) ? ONE_Q16 : ZERO_Q16;
			else
				level = q16_t'($urandom_range(65536));
			spread = q16_t'($urandom_range(20000));
			mode = $urandom_range(3);
			d = (force_drain && made == 0) || ($urandom_range(9) == 0);
			lo = (level > spread) ? level - spread : ZERO_Q16;
			hi = (level + spread > ONE_Q16) ? ONE_Q16 : level + spread;
			for (i = 0; i < n; i++) begin
				if ($urandom_range(32) == 0)
					e = q16_t'($urandom_range(131071, 65537));
				else
					e = q16_t'($urandom_range(hi, lo));
				case (mode)
					1: c = CLS_GOOD;
					2: c = CLS_BAD;
					3: c = (i % 2) ? CLS_BAD : CLS_GOOD;
					default: begin
						pick = $urandom_range(99);
						if (pick < 35)
							c = CLS_GOOD;
						else if (pick < 70)
							c = CLS_BAD;
						else if (pick < 88)
							c = CLS_NONE;
						else
							c = CLS_UNUSED;
					end
				endcase
				push_req(e, c, d && i == 0);
			end
			made += n;
		end
	endtask

	// stimulus sequence
	initial begin
		int unsigned p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed opener at reset factors: error extremes, every class code
		push_req(ZERO_Q16, CLS_GOOD, 1'b0);
		push_req(ZERO_Q16, CLS_BAD, 1'b0);
		push_req(ONE_Q16, CLS_GOOD, 1'b0);
		push_req(ONE_Q16, CLS_BAD, 1'b0);
		push_req(q16_t'('1), CLS_GOOD, 1'b0);
		push_req(ONE_Q16 + 17'd1, CLS_BAD, 1'b0);
		push_req(ZERO_Q16, CLS_NONE, 1'b0);
		push_req(ONE_Q16, CLS_UNUSED, 1'b0);
		push_req(q16_t'('1), CLS_NONE, 1'b0);
		push_req(17'd1, CLS_GOOD, 1'b0);
		push_req(ONE_Q16 - 17'd1, CLS_BAD, 1'b0);
		push_req(HALF_Q16, CLS_UNUSED, 1'b0);
		for (p = 0; p < 6; p++)
			push_req(ZERO_Q16, (p % 2) ? CLS_BAD : CLS_GOOD, 1'b0);
		for (p = 0; p < 4; p++)
			push_req(ONE_Q16, CLS_NONE, 1'b0);
		wait_drained();

		// random phases, each with its own factors and one of four idle/stall patterns
		for (p = 1; p <= RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			case (p)
				1: begin
					write_reg(REG_GEN_FORGET, ONE_Q16);
					write_reg(REG_LOCAL_FORGET, ONE_Q16);
					write_reg(REG_GOOD_FORGET, ONE_Q16);
					write_reg(REG_BAD_FORGET, ONE_Q16);
				end
				2: begin
					write_reg(REG_GEN_FORGET, ZERO_Q16);
					write_reg(REG_LOCAL_FORGET, ZERO_Q16);
					write_reg(REG_GOOD_FORGET, ZERO_Q16);
					write_reg(REG_BAD_FORGET, ZERO_Q16);
				end
				3: begin
					write_reg(REG_GEN_FORGET, FACTOR_ALL_ONES);
					write_reg(REG_LOCAL_FORGET, FACTOR_ALL_ONES);
					write_reg(REG_GOOD_FORGET, FACTOR_ALL_ONES);
					write_reg(REG_BAD_FORGET, FACTOR_ALL_ONES);
				end
				default: begin
					write_reg(REG_GEN_FORGET, pick_factor());
					write_reg(REG_LOCAL_FORGET, pick_factor());
					write_reg(REG_GOOD_FORGET, pick_factor());
					write_reg(REG_BAD_FORGET, pick_factor());
				end
			endcase
			// writes to unassigned indexes must leave every factor alone
			write_reg(cfg_idx_t'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
			          q16_t'($urandom_range(131071)));
			write_reg(REG_SPARE_LAST, FACTOR_ALL_ONES);
			add_random_reqs(PHASE_REQS, p == 1);
			wait_drained();
		end

		$display("ran %0d requests, %0d reports, %0d factor settings",
		         req_cnt, report_cnt, RANDOM_PHASES + 1);
		$display("best mean improved %0d times, %0d field mismatches",
		         best_hits, mismatch_cnt);
		if (mismatch_cnt == 0 && report_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
